// ----- rtl/core/mets_pkg.sv -----
// mets_pkg: shared types, fixed-point constants and helpers for the
// Mandelbrot escape-time core. No dependencies.
`default_nettype none
package mets_pkg;

    localparam int FRAC = 28;
    localparam logic [63:0] ONE_Q    = 64'h0000_0000_1000_0000;
    localparam logic [63:0] QUARTER  = 64'h0000_0000_0400_0000;
    localparam logic [63:0] PROD_LIM = 64'h1000_0000_0000_0000;
    localparam logic [63:0] LN2_Q    = 64'd186065280;
    localparam logic [63:0] VAL_MAX  = 64'h0000_007F_FFFF_FFFF;
    localparam logic [63:0] VAL_MIN  = 64'hFFFF_FF80_0000_0000;
    localparam logic [63:0] VAL_INS  = 64'hFFFF_FFFF_FFFF_0000;
    localparam logic [63:0] BULB_LIM = 64'h0010_0000_0000_0000;
    localparam logic [63:0] BAIL4    = 64'h0000_0000_4000_0000;
    localparam logic [63:0] BAIL16   = 64'h0000_0001_0000_0000;

    // register indexes
    localparam logic REG_MAX_ITER    = 1'b0;
    localparam logic REG_SMOOTH_MODE = 1'b1;

    // smoothing modes
    localparam logic [1:0] MODE_PLAIN  = 2'd0;
    localparam logic [1:0] MODE_LINEAR = 2'd1;
    localparam logic [1:0] MODE_LOG    = 2'd2;
    localparam logic [1:0] MODE_DIST   = 2'd3;

    typedef struct packed {
        logic        start;
        logic [63:0] a;
        logic [63:0] b;
    } mul_req_t;

    typedef struct packed {
        logic        start;
        logic        is_div;
        logic [63:0] a;   // radicand or dividend
        logic [63:0] b;   // divisor
    } sqd_req_t;

    function automatic logic [63:0] mag64(input logic [63:0] v);
        mag64 = v[63] ? (64'd0 - v) : v;
    endfunction

    // floor(+-prod / 2^sh), sh is 27 or 28, saturated to +-2^60
    function automatic logic [63:0] mulshr(input logic [127:0] prod, input logic neg,
                                           input logic sh27);
        logic [127:0] q;
        logic         rem;
        logic [63:0]  m;
        q   = sh27 ? (prod >> 27) : (prod >> 28);
        rem = sh27 ? (|prod[26:0]) : (|prod[27:0]);
        if (neg && rem)
            q = q + 128'd1;
        if ((q[127:64] != 64'd0) || (q[63:0] > PROD_LIM))
            m = PROD_LIM;
        else
            m = q[63:0];
        mulshr = neg ? (64'd0 - m) : m;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/core/mets_mul.sv -----
// mets_mul: shared 64x64 unsigned multiplier built from one registered
// 32x32 partial-product multiplier. Uses mets_pkg.
`default_nettype none
module mets_mul
    import mets_pkg::*;
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire mul_req_t       req,
    output logic                done,
    output logic [127:0]        prod
);

    logic [63:0]  a_reg, b_reg, p_reg;
    logic [1:0]   psh_reg;
    logic [127:0] acc_reg, acc_next;
    logic [2:0]   cnt_reg;
    logic         busy_reg, pv_reg, done_reg;
    logic [31:0]  pa, pb;
    logic [1:0]   psh_next;

    always_comb
    begin
        case (cnt_reg[1:0])
            2'd0:
            begin
                pa = a_reg[31:0];  pb = b_reg[31:0];  psh_next = 2'd0;
            end
            2'd1:
            begin
                pa = a_reg[31:0];  pb = b_reg[63:32]; psh_next = 2'd1;
            end
            2'd2:
            begin
                pa = a_reg[63:32]; pb = b_reg[31:0];  psh_next = 2'd1;
            end
            default:
            begin
                pa = a_reg[63:32]; pb = b_reg[63:32]; psh_next = 2'd2;
            end
        endcase
        acc_next = acc_reg + ({64'd0, p_reg} << (7'd32 * {5'd0, psh_reg}));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            pv_reg   <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 3'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                pv_reg   <= 1'b0;
                cnt_reg  <= 3'd0;
            end
            else if (busy_reg)
            begin
                if (!cnt_reg[2])
                begin
                    pv_reg  <= 1'b1;
                    cnt_reg <= cnt_reg + 3'd1;
                end
                else
                begin
                    busy_reg <= 1'b0;
                    pv_reg   <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            a_reg   <= req.a;
            b_reg   <= req.b;
            acc_reg <= 128'd0;
        end
        else if (busy_reg)
        begin
            if (!cnt_reg[2])
            begin
                p_reg   <= {32'd0, pa} * {32'd0, pb};
                psh_reg <= psh_next;
            end
            if (pv_reg)
                acc_reg <= acc_next;
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule
`default_nettype wire

// ----- rtl/core/mets_sqdiv.sv -----
// mets_sqdiv: bit-serial floor square root (32 steps) and unsigned
// 64/64 division (64 steps) sharing one subtract/compare. Uses mets_pkg.
`default_nettype none
module mets_sqdiv
    import mets_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire sqd_req_t req,
    output logic          done,
    output logic [63:0]   result
);

    logic [63:0] sh_reg, d_reg, res_reg;
    logic [65:0] rem_reg, rem_in, trial, diff;
    logic [5:0]  cnt_reg;
    logic        busy_reg, div_reg, done_reg, ge;

    always_comb
    begin
        if (div_reg)
        begin
            rem_in = {rem_reg[64:0], sh_reg[63]};
            trial  = {2'b00, d_reg};
        end
        else
        begin
            rem_in = {rem_reg[63:0], sh_reg[63:62]};
            trial  = {res_reg, 2'b01};
        end
        diff = rem_in - trial;
        ge   = (rem_in >= trial);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= req.is_div ? 6'd63 : 6'd31;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            div_reg <= req.is_div;
            sh_reg  <= req.a;
            d_reg   <= req.b;
            rem_reg <= 66'd0;
            res_reg <= 64'd0;
        end
        else if (busy_reg)
        begin
            sh_reg  <= div_reg ? (sh_reg << 1) : (sh_reg << 2);
            rem_reg <= ge ? diff : rem_in;
            res_reg <= {res_reg[62:0], ge};
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule
`default_nettype wire

// ----- rtl/core/mandelbrot_escape_time_smooth_core.sv -----
// Mandelbrot escape-time core with smooth coloring: sequencer, state and
// fixed-point datapath around mets_mul and mets_sqdiv. Uses mets_pkg.
// Sequence: bulb tests (four shared multiplies), then per iteration three
//   multiplies and the loop test (seven multiplies in distance mode), then a
//   finish that depends on the smoothing mode (none in plain mode), then the
//   output register.
// Throughput: one item in flight; the next item is taken only after the
//   result is registered, so a new item waits until the last one is done.
// Reset: asynchronous, active low; registers return to 256 / plain mode.
`default_nettype none
module mandelbrot_escape_time_smooth_core
    import mets_pkg::*;
#(
    parameter int COORD_WIDTH = 32,   // coordinate width, Q4.28 at 32
    parameter int ITER_WIDTH  = 16    // iteration counter width
)
(
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    // input items
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    input  wire logic [((2*COORD_WIDTH+7)/8)*8-1:0]   s_tdata,  // cx, cy
    // result items
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    output logic [39:0]                               m_tdata,  // value
    output logic                                      m_tuser,  // inside_res
    // configuration writes
    input  wire logic                                 cfg_we,
    input  wire logic                                 cfg_index,
    input  wire logic [15:0]                          cfg_data
);

    // sequencer states
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_ISSUE  = 4'd1;   // start a multiply
    localparam logic [3:0] S_MWAIT  = 4'd2;   // wait for product, write back
    localparam logic [3:0] S_DISSUE = 4'd3;   // start sqrt / divide
    localparam logic [3:0] S_DWAIT  = 4'd4;
    localparam logic [3:0] S_CHK    = 4'd5;   // loop test and finish select
    localparam logic [3:0] S_LOGN   = 4'd6;   // log2 normalize, one bit a cycle
    localparam logic [3:0] S_LDONE  = 4'd7;   // log2 result dispatch
    localparam logic [3:0] S_SCALE  = 4'd8;   // derivative pre-scale
    localparam logic [3:0] S_OUT    = 4'd9;

    // operations of the shared units
    localparam logic [4:0] OP_Y56  = 5'd0;
    localparam logic [4:0] OP_U2   = 5'd1;
    localparam logic [4:0] OP_CARD = 5'd2;
    localparam logic [4:0] OP_BULB = 5'd3;
    localparam logic [4:0] OP_ZY   = 5'd4;
    localparam logic [4:0] OP_X2   = 5'd5;
    localparam logic [4:0] OP_Y2   = 5'd6;
    localparam logic [4:0] OP_D1   = 5'd7;
    localparam logic [4:0] OP_D2   = 5'd8;
    localparam logic [4:0] OP_D3   = 5'd9;
    localparam logic [4:0] OP_D4   = 5'd10;
    localparam logic [4:0] OP_LSQ  = 5'd11;
    localparam logic [4:0] OP_LNM  = 5'd12;
    localparam logic [4:0] OP_N    = 5'd13;
    localparam logic [4:0] OP_AX2  = 5'd14;
    localparam logic [4:0] OP_AY2  = 5'd15;
    localparam logic [4:0] OP_SQA  = 5'd16;
    localparam logic [4:0] OP_SQB  = 5'd17;
    localparam logic [4:0] OP_DIV1 = 5'd18;
    localparam logic [4:0] OP_SQM  = 5'd19;
    localparam logic [4:0] OP_DIV3 = 5'd20;

    // log2 call sites
    localparam logic [1:0] LP_A  = 2'd0;   // log mode, log2 |z|^2
    localparam logic [1:0] LP_B  = 2'd1;   // log mode, log2 of that
    localparam logic [1:0] LP_M3 = 2'd2;   // distance mode

    // configuration
    logic [15:0] max_iter_reg;
    logic [1:0]  mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_iter_reg <= 16'd256;
            mode_reg     <= MODE_PLAIN;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MAX_ITER:    max_iter_reg <= cfg_data;
                REG_SMOOTH_MODE: mode_reg     <= cfg_data[1:0];
                default:         max_iter_reg <= max_iter_reg;
            endcase
        end
    end

    logic [ITER_WIDTH-1:0] cap;
    assign cap = ITER_WIDTH'(max_iter_reg);

    // control state
    logic [3:0] state_reg, state_next;
    logic [4:0] op_reg, op_next;
    logic [1:0] lphase_reg, lphase_next;
    logic [ITER_WIDTH-1:0] it_reg, it_next;
    logic       inside_reg, inside_next;
    logic       ovalid_reg, ovalid_next;

    // datapath
    logic [63:0] cx_reg, cy_reg, zx_reg, zy_reg, x2_reg, y2_reg, pm_reg;
    logic [63:0] dzx_reg, dzy_reg, ta_reg, tb_reg, y56_reg, val_reg;
    logic [63:0] cx_next, cy_next, zx_next, zy_next, x2_next, y2_next, pm_next;
    logic [63:0] dzx_next, dzy_next, ta_next, tb_next, y56_next, val_next;
    logic [63:0] lx_reg, lx_next, lres_reg, lres_next;
    logic [5:0]  lk_reg, lk_next, s_reg, s_next;
    logic [29:0] ly_reg, ly_next;
    logic [27:0] lfrac_reg, lfrac_next, lfrac_upd;
    logic [4:0]  lcnt_reg, lcnt_next;
    logic [39:0] odata_reg, odata_next;
    logic        ouser_reg, ouser_next;

    // shared units
    mul_req_t     mreq;
    sqd_req_t     dreq;
    logic         mdone, ddone;
    logic [127:0] prod;
    logic [63:0]  dres;

    mets_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mreq),
        .done  (mdone),
        .prod  (prod)
    );

    mets_sqdiv u_sqdiv (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (dreq),
        .done   (ddone),
        .result (dres)
    );

    // helpers
    logic [63:0] u_val, uq, xp, msum, bail, r, nx, ny, t_lsq, t4sum, mx;
    logic [63:0] num1, den1;
    logic [29:0] lt;
    logic        mneg, msh27;

    assign u_val = cx_reg - QUARTER;
    assign uq    = ta_reg + u_val;
    assign xp    = cx_reg + ONE_Q;
    assign msum  = x2_reg + y2_reg;
    assign bail  = (mode_reg == MODE_LOG) ? BAIL16 : BAIL4;
    assign lt    = prod[57:28];
    assign mx    = (zx_reg > zy_reg) ? zx_reg : zy_reg;
    assign num1  = (64'h0000_0000_0800_0000 - tb_reg) << 16;
    assign den1  = (ta_reg > tb_reg) ? (ta_reg - tb_reg) : 64'd1;

    // multiply operand select
    always_comb
    begin
        mreq.start = (state_reg == S_ISSUE);
        mreq.a     = 64'd0;
        mreq.b     = 64'd0;
        mneg       = 1'b0;
        msh27      = 1'b0;
        case (op_reg)
            OP_Y56:  begin mreq.a = mag64(cy_reg); mreq.b = mag64(cy_reg); end
            OP_U2:   begin mreq.a = mag64(u_val);  mreq.b = mag64(u_val);  end
            OP_CARD:
            begin
                mreq.a = ta_reg; mreq.b = mag64(uq); mneg = uq[63];
            end
            OP_BULB: begin mreq.a = mag64(xp); mreq.b = mag64(xp); end
            OP_ZY:
            begin
                mreq.a = mag64(zx_reg); mreq.b = mag64(zy_reg);
                mneg   = zx_reg[63] ^ zy_reg[63]; msh27 = 1'b1;
            end
            OP_X2:   begin mreq.a = mag64(zx_reg); mreq.b = mag64(zx_reg); end
            OP_Y2:   begin mreq.a = mag64(zy_reg); mreq.b = mag64(zy_reg); end
            OP_D1:
            begin
                mreq.a = mag64(zx_reg); mreq.b = mag64(dzx_reg);
                mneg   = zx_reg[63] ^ dzx_reg[63];
            end
            OP_D2:
            begin
                mreq.a = mag64(zy_reg); mreq.b = mag64(dzy_reg);
                mneg   = zy_reg[63] ^ dzy_reg[63];
            end
            OP_D3:
            begin
                mreq.a = mag64(zy_reg); mreq.b = mag64(dzx_reg);
                mneg   = zy_reg[63] ^ dzx_reg[63];
            end
            OP_D4:
            begin
                mreq.a = mag64(zx_reg); mreq.b = mag64(dzy_reg);
                mneg   = zx_reg[63] ^ dzy_reg[63];
            end
            OP_LSQ:  begin mreq.a = {34'd0, ly_reg}; mreq.b = {34'd0, ly_reg}; end
            OP_LNM:
            begin
                mreq.a = mag64(ta_reg); mreq.b = LN2_Q; mneg = ta_reg[63];
            end
            OP_N:
            begin
                mreq.a = mag64(msum); mreq.b = mag64(ta_reg);
                mneg   = msum[63] ^ ta_reg[63];
            end
            OP_AX2:  begin mreq.a = zx_reg; mreq.b = zx_reg; end
            OP_AY2:  begin mreq.a = zy_reg; mreq.b = zy_reg; end
            default: begin mreq.a = 64'd0;  mreq.b = 64'd0;  end
        endcase
    end

    // sqrt / divide operand select
    always_comb
    begin
        dreq.start  = (state_reg == S_DISSUE);
        dreq.is_div = 1'b0;
        dreq.a      = 64'd0;
        dreq.b      = 64'd1;
        case (op_reg)
            OP_SQA:  dreq.a = msum << 24;
            OP_SQB:  dreq.a = pm_reg << 24;
            OP_DIV1: begin dreq.is_div = 1'b1; dreq.a = num1; dreq.b = den1; end
            OP_SQM:  dreq.a = ta_reg;
            OP_DIV3: begin dreq.is_div = 1'b1; dreq.a = tb_reg << 16; dreq.b = ta_reg; end
            default: dreq.a = 64'd0;
        endcase
    end

    // product post-processing
    assign r      = mulshr(prod, mneg, msh27);
    assign nx     = (ta_reg << 1) + ONE_Q;
    assign t4sum  = (tb_reg + r) << 1;
    assign t_lsq  = {34'd0, lt};

    always_comb
    begin
        lfrac_upd = lfrac_reg;
        if (lt[29])
            lfrac_upd[lcnt_reg] = 1'b1;
    end

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        lphase_next = lphase_reg;
        it_next     = it_reg;
        inside_next = inside_reg;
        ovalid_next = ovalid_reg;
        cx_next  = cx_reg;  cy_next  = cy_reg;  zx_next  = zx_reg;  zy_next = zy_reg;
        x2_next  = x2_reg;  y2_next  = y2_reg;  pm_next  = pm_reg;
        dzx_next = dzx_reg; dzy_next = dzy_reg; ta_next  = ta_reg;  tb_next = tb_reg;
        y56_next = y56_reg; val_next = val_reg;
        lx_next  = lx_reg;  lres_next = lres_reg; lk_next = lk_reg; s_next = s_reg;
        ly_next  = ly_reg;  lfrac_next = lfrac_reg; lcnt_next = lcnt_reg;
        odata_next = odata_reg;
        ouser_next = ouser_reg;
        ny = 64'd0;

        if (ovalid_reg && m_tready)
            ovalid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cx_next  = 64'($signed(s_tdata[COORD_WIDTH-1:0]));
                    cy_next  = 64'($signed(s_tdata[2*COORD_WIDTH-1:COORD_WIDTH]));
                    zx_next  = 64'd0; zy_next = 64'd0;
                    x2_next  = 64'd0; y2_next = 64'd0; pm_next = 64'd0;
                    dzx_next = ONE_Q; dzy_next = 64'd0;
                    it_next  = '0;
                    inside_next = 1'b0;
                    op_next  = OP_Y56;
                    state_next = S_ISSUE;
                end
            end

            S_ISSUE:
                state_next = S_MWAIT;

            S_MWAIT:
            begin
                if (mdone)
                begin
                    state_next = S_ISSUE;
                    case (op_reg)
                        OP_Y56:
                        begin
                            y56_next = prod[63:0];
                            op_next  = OP_U2;
                        end
                        OP_U2:
                        begin
                            ta_next = (prod[63:0] + y56_reg) >> FRAC;
                            op_next = OP_CARD;
                        end
                        OP_CARD:
                        begin
                            inside_next = ($signed(r) <= $signed({30'd0, y56_reg[63:30]}));
                            op_next = OP_BULB;
                        end
                        OP_BULB:
                        begin
                            if (inside_reg || ((prod[63:0] + y56_reg) <= BULB_LIM))
                            begin
                                inside_next = 1'b1;
                                val_next    = VAL_INS;
                                state_next  = S_OUT;
                            end
                            else
                                state_next = S_CHK;
                        end
                        OP_ZY:
                        begin
                            zy_next = r + cy_reg;
                            zx_next = x2_reg - y2_reg + cx_reg;
                            op_next = OP_X2;
                        end
                        OP_X2:
                        begin
                            x2_next = r;
                            op_next = OP_Y2;
                        end
                        OP_Y2:
                        begin
                            y2_next = r;
                            if (mode_reg == MODE_DIST)
                                op_next = OP_D1;
                            else
                            begin
                                it_next    = it_reg + ITER_WIDTH'(1);
                                state_next = S_CHK;
                            end
                        end
                        OP_D1:
                        begin
                            ta_next = r;
                            op_next = OP_D2;
                        end
                        OP_D2:
                        begin
                            ta_next = ta_reg - r;
                            op_next = OP_D3;
                        end
                        OP_D3:
                        begin
                            tb_next = r;
                            op_next = OP_D4;
                        end
                        OP_D4:
                        begin
                            ny = t4sum;
                            // clamp both derivative parts to +-2^60
                            if ($signed(nx) > $signed(PROD_LIM))
                                dzx_next = PROD_LIM;
                            else if ($signed(nx) < -$signed(PROD_LIM))
                                dzx_next = 64'd0 - PROD_LIM;
                            else
                                dzx_next = nx;
                            if ($signed(ny) > $signed(PROD_LIM))
                                dzy_next = PROD_LIM;
                            else if ($signed(ny) < -$signed(PROD_LIM))
                                dzy_next = 64'd0 - PROD_LIM;
                            else
                                dzy_next = ny;
                            it_next    = it_reg + ITER_WIDTH'(1);
                            state_next = S_CHK;
                        end
                        OP_LSQ:
                        begin
                            ly_next    = lt[29] ? {1'b0, lt[29:1]} : t_lsq[29:0];
                            lfrac_next = lfrac_upd;
                            if (lcnt_reg == 5'd0)
                            begin
                                lres_next  = ((64'd35 - {58'd0, lk_reg}) << FRAC)
                                             | {36'd0, lfrac_upd};
                                state_next = S_LDONE;
                            end
                            else
                                lcnt_next = lcnt_reg - 5'd1;
                        end
                        OP_LNM:
                        begin
                            ta_next = r;
                            op_next = OP_N;
                        end
                        OP_N:
                        begin
                            tb_next    = r[63] ? 64'd0 : r;
                            zx_next    = mag64(dzx_reg);
                            zy_next    = mag64(dzy_reg);
                            s_next     = 6'd0;
                            state_next = S_SCALE;
                        end
                        OP_AX2:
                        begin
                            ta_next = prod[63:0];
                            op_next = OP_AY2;
                        end
                        OP_AY2:
                        begin
                            ta_next    = ta_reg + prod[63:0];
                            op_next    = OP_SQM;
                            state_next = S_DISSUE;
                        end
                        default:
                            state_next = S_OUT;
                    endcase
                end
            end

            S_CHK:
            begin
                if (($signed(msum) < $signed(bail)) && (it_reg < cap))
                begin
                    pm_next    = msum;
                    op_next    = OP_ZY;
                    state_next = S_ISSUE;
                end
                else if (it_reg == cap)
                begin
                    inside_next = 1'b1;
                    val_next    = VAL_INS;
                    state_next  = S_OUT;
                end
                else
                begin
                    val_next = 64'(it_reg) << 16;
                    case (mode_reg)
                        MODE_LINEAR:
                        begin
                            op_next    = OP_SQA;
                            state_next = S_DISSUE;
                        end
                        MODE_LOG:
                        begin
                            lx_next     = msum;
                            lk_next     = 6'd0;
                            lphase_next = LP_A;
                            state_next  = S_LOGN;
                        end
                        MODE_DIST:
                        begin
                            lx_next     = msum;
                            lk_next     = 6'd0;
                            lphase_next = LP_M3;
                            state_next  = S_LOGN;
                        end
                        default:
                            state_next = S_OUT;
                    endcase
                end
            end

            S_LOGN:
            begin
                if (lx_reg == 64'd0)
                begin
                    lres_next  = 64'd0;
                    state_next = S_LDONE;
                end
                else if (!lx_reg[63])
                begin
                    lx_next = lx_reg << 1;
                    lk_next = lk_reg + 6'd1;
                end
                else
                begin
                    // mantissa in [1,2) as Q28
                    ly_next    = {1'b0, lx_reg[63:35]};
                    lfrac_next = 28'd0;
                    lcnt_next  = 5'd27;
                    op_next    = OP_LSQ;
                    state_next = S_ISSUE;
                end
            end

            S_LDONE:
            begin
                case (lphase_reg)
                    LP_A:
                    begin
                        lx_next     = $signed(lres_reg) > 0 ? lres_reg : 64'd0;
                        lk_next     = 6'd0;
                        lphase_next = LP_B;
                        state_next  = S_LOGN;
                    end
                    LP_B:
                    begin
                        val_next   = val_reg
                                   + 64'($signed(64'h0000_0000_2000_0000 - lres_reg) >>> 12);
                        state_next = S_OUT;
                    end
                    default:
                    begin
                        ta_next    = lres_reg;
                        op_next    = OP_LNM;
                        state_next = S_ISSUE;
                    end
                endcase
            end

            S_SCALE:
            begin
                if (mx[63:31] != 33'd0)
                begin
                    zx_next = zx_reg >> 1;
                    zy_next = zy_reg >> 1;
                    s_next  = s_reg + 6'd1;
                end
                else
                begin
                    op_next    = OP_AX2;
                    state_next = S_ISSUE;
                end
            end

            S_DISSUE:
                state_next = S_DWAIT;

            S_DWAIT:
            begin
                if (ddone)
                begin
                    case (op_reg)
                        OP_SQA:
                        begin
                            ta_next    = dres;
                            op_next    = OP_SQB;
                            state_next = S_DISSUE;
                        end
                        OP_SQB:
                        begin
                            tb_next    = dres;
                            op_next    = OP_DIV1;
                            state_next = S_DISSUE;
                        end
                        OP_DIV1:
                        begin
                            val_next   = val_reg + dres;
                            state_next = S_OUT;
                        end
                        OP_SQM:
                        begin
                            if (dres == 64'd0)
                            begin
                                val_next   = VAL_MAX;
                                state_next = S_OUT;
                            end
                            else
                            begin
                                ta_next    = dres;
                                op_next    = OP_DIV3;
                                state_next = S_DISSUE;
                            end
                        end
                        default:
                        begin
                            val_next   = dres >> s_reg;
                            state_next = S_OUT;
                        end
                    endcase
                end
            end

            S_OUT:
            begin
                // output register frees the sequencer for the next item
                if (!ovalid_reg || m_tready)
                begin
                    ovalid_next = 1'b1;
                    ouser_next  = inside_reg;
                    if ($signed(val_reg) > $signed(VAL_MAX))
                        odata_next = VAL_MAX[39:0];
                    else if ($signed(val_reg) < $signed(VAL_MIN))
                        odata_next = VAL_MIN[39:0];
                    else
                        odata_next = val_reg[39:0];
                    state_next = S_IDLE;
                end
            end

            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            op_reg     <= OP_Y56;
            lphase_reg <= LP_A;
            it_reg     <= '0;
            inside_reg <= 1'b0;
            ovalid_reg <= 1'b0;
            lk_reg     <= 6'd0;
            lcnt_reg   <= 5'd0;
            s_reg      <= 6'd0;
        end
        else
        begin
            state_reg  <= state_next;
            op_reg     <= op_next;
            lphase_reg <= lphase_next;
            it_reg     <= it_next;
            inside_reg <= inside_next;
            ovalid_reg <= ovalid_next;
            lk_reg     <= lk_next;
            lcnt_reg   <= lcnt_next;
            s_reg      <= s_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cx_reg  <= cx_next;  cy_reg  <= cy_next;  zx_reg <= zx_next; zy_reg <= zy_next;
        x2_reg  <= x2_next;  y2_reg  <= y2_next;  pm_reg <= pm_next;
        dzx_reg <= dzx_next; dzy_reg <= dzy_next; ta_reg <= ta_next; tb_reg <= tb_next;
        y56_reg <= y56_next; val_reg <= val_next;
        lx_reg  <= lx_next;  lres_reg <= lres_next;
        ly_reg  <= ly_next;  lfrac_reg <= lfrac_next;
        odata_reg <= odata_next;
        ouser_reg <= ouser_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = ovalid_reg;
    assign m_tdata  = odata_reg;
    assign m_tuser  = ouser_reg;

endmodule
`default_nettype wire

// ----- rtl/core/mets_checker.sv -----
// mets_checker: port-level checks for the escape-time core, bound to the
// top level. Uses only the top-level ports.
`default_nettype none
module mets_checker #(
    parameter int COORD_WIDTH = 32
)
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_tvalid,
    input  wire logic                               s_tready,
    input  wire logic [((2*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
    input  wire logic                               m_tvalid,
    input  wire logic                               m_tready,
    input  wire logic [39:0]                        m_tdata,
    input  wire logic                               m_tuser
);

    // one item at a time: busy right after an accept
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("core ready right after accepting an item");

    // inside points always report -1.0
    a_inside_value: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata == 40'hFF_FFFF_0000))
        else $error("inside item with value other than -1.0");

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result item changed");

    // no input is taken while the core is not ready, that is while
    // the sequencer is busy (result and new accept stay ordered)
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (!s_tready) |-> !(s_tvalid && s_tready))
        else $error("item accepted while busy");

endmodule

bind mandelbrot_escape_time_smooth_core mets_checker #(.COORD_WIDTH(COORD_WIDTH)) u_chk (.*);
`default_nettype wire
